FILE: rtl/wialu_pkg.sv
// Shared constants and operation codes for the wide integer ALU with compact codec.
package wialu_pkg;

    // operand geometry
    localparam int WIA_WORD_COUNT = 4;
    localparam int WIA_WORD_W     = 64;
    localparam int WIA_POS_W      = $clog2(WIA_WORD_W);

    // operation codes
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_ADD    = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB    = 4'd1;
    localparam logic [OP_W-1:0] OP_AND    = 4'd2;
    localparam logic [OP_W-1:0] OP_OR     = 4'd3;
    localparam logic [OP_W-1:0] OP_XOR    = 4'd4;
    localparam logic [OP_W-1:0] OP_EQ     = 4'd5;
    localparam logic [OP_W-1:0] OP_NE     = 4'd6;
    localparam logic [OP_W-1:0] OP_LT     = 4'd7;
    localparam logic [OP_W-1:0] OP_GT     = 4'd8;
    localparam logic [OP_W-1:0] OP_LE     = 4'd9;
    localparam logic [OP_W-1:0] OP_GE     = 4'd10;
    localparam logic [OP_W-1:0] OP_DECODE = 4'd11;
    localparam logic [OP_W-1:0] OP_ENCODE = 4'd12;

    // compact word layout: size byte, sign bit, 23-bit mantissa
    localparam int CW_W      = 32;
    localparam int MANT_W    = 23;
    localparam int MANT_B    = 24;    // mantissa plus sign position
    localparam int CW_SIZE_W = 8;
    localparam logic [CW_SIZE_W-1:0] CW_MANT_BYTES = 8'd3;

    // decode overflow limits on the size byte
    localparam logic [CW_SIZE_W-1:0] CW_OVF_ANY  = 8'd34;
    localparam logic [CW_SIZE_W-1:0] CW_OVF_BYTE = 8'd33;
    localparam logic [CW_SIZE_W-1:0] CW_OVF_HALF = 8'd32;
    localparam logic [MANT_W-1:0]    MANT_BYTE_MAX = 23'h0000ff;
    localparam logic [MANT_W-1:0]    MANT_HALF_MAX = 23'h00ffff;

endpackage

FILE: rtl/wide_integer_alu_with_compact_codec.sv
// Top level: 256-bit unsigned ALU with compact (nBits) encode and decode, three-stage pipeline.
//
//  channel  | dir | tdata (low bit up)                  | tuser (low bit up)
//  ---------+-----+-------------------------------------+---------------------------------
//  s_axis   | in  | a_word0..a_word3, b_word0..b_word3  | operation[3:0], encode_negative
//  m_axis   | out | result_word0..result_word3          | compare_true, negative_flag,
//           |     |                                     | overflow_flag
//
// One word accepted per cycle while m_axis is not stalled; each word passes stages 1, 2 and 3 before it leaves.
// Stage 1: lane adds, lane compares, lane leading-one search, compact field split.
// Stage 2: carry resolution, compare merge, bit length, decode byte placement.
// Stage 3 (output register): encode byte extraction and compact word assembly.
// Reset clears the three stage valid bits only. A stall on m_axis freezes all
// stages together; s_axis_tready is high whenever the output register is empty
// or being taken.
module wide_integer_alu_with_compact_codec
    import wialu_pkg::*;
#(
    parameter int WORD_COUNT = WIA_WORD_COUNT
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // a_word0..a_word3, b_word0..b_word3
    input  logic [2*WORD_COUNT*WIA_WORD_W-1:0]     s_axis_tdata,
    // operation[3:0], encode_negative[4]
    input  logic [OP_W:0]                          s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // result_word0..result_word3
    output logic [WORD_COUNT*WIA_WORD_W-1:0]       m_axis_tdata,
    // compare_true[0], negative_flag[1], overflow_flag[2]
    output logic [2:0]                             m_axis_tuser
);

    localparam int DATA_W  = WORD_COUNT * WIA_WORD_W;
    localparam int BITS_W  = $clog2(DATA_W + 1);
    localparam int SIZE_W  = $clog2(DATA_W / 8 + 1);
    localparam int BSH_W   = $clog2(DATA_W / 8);

    // pipeline advance: all stages move together
    logic w_adv;
    logic r_s3_valid;
    assign w_adv         = !r_s3_valid || m_axis_tready;
    assign s_axis_tready = w_adv;

    logic [DATA_W-1:0] w_a;
    logic [DATA_W-1:0] w_b;
    logic [OP_W-1:0]   w_op;
    assign w_a  = s_axis_tdata[DATA_W-1:0];
    assign w_b  = s_axis_tdata[2*DATA_W-1:DATA_W];
    assign w_op = s_axis_tuser[OP_W-1:0];

    // ---------------- stage 1 ----------------
    logic                                 r_s1_valid;
    logic [OP_W-1:0]                      r_s1_op, n_s1_op;
    logic [DATA_W-1:0]                    r_s1_data, n_s1_data;
    logic [WORD_COUNT-1:0]                r_s1_g, n_s1_g;
    logic [WORD_COUNT-1:0]                r_s1_p, n_s1_p;
    logic [WORD_COUNT-1:0]                r_s1_eq, n_s1_eq;
    logic [WORD_COUNT-1:0]                r_s1_lt, n_s1_lt;
    logic [WORD_COUNT-1:0]                r_s1_nz, n_s1_nz;
    logic [WORD_COUNT-1:0][WIA_POS_W-1:0] r_s1_pos, n_s1_pos;
    logic [CW_SIZE_W-1:0]                 r_s1_dsize, n_s1_dsize;
    logic                                 r_s1_neg, n_s1_neg;
    logic                                 r_s1_ovf, n_s1_ovf;
    logic                                 r_s1_encneg, n_s1_encneg;

    // lane sums, lane compares, leading-one search, compact field split
    always_comb begin
        logic [WIA_WORD_W-1:0] a_l;
        logic [WIA_WORD_W-1:0] b_l;
        logic [WIA_WORD_W:0]   lsum;
        logic [DATA_W-1:0]     sums;
        logic                  is_sub;
        logic [MANT_W-1:0]     mant;
        logic [MANT_W-1:0]     madj;
        logic                  sgn;

        is_sub = (w_op == OP_SUB);
        sums   = '0;
        for (int i = 0; i < WORD_COUNT; i++) begin
            a_l  = w_a[i*WIA_WORD_W +: WIA_WORD_W];
            b_l  = w_b[i*WIA_WORD_W +: WIA_WORD_W];
            lsum = {1'b0, a_l} + {1'b0, (is_sub ? ~b_l : b_l)}
                 + (WIA_WORD_W+1)'(is_sub && (i == 0));
            sums[i*WIA_WORD_W +: WIA_WORD_W] = lsum[WIA_WORD_W-1:0];
            n_s1_g[i]  = lsum[WIA_WORD_W];
            n_s1_p[i]  = &lsum[WIA_WORD_W-1:0];
            n_s1_eq[i] = (a_l == b_l);
            n_s1_lt[i] = (a_l < b_l);
            n_s1_nz[i] = |a_l;
            n_s1_pos[i] = '0;
            for (int j = 0; j < WIA_WORD_W; j++) begin
                if (a_l[j]) begin
                    n_s1_pos[i] = WIA_POS_W'(j);
                end
            end
        end

        // compact word fields; small sizes shift the mantissa right here
        n_s1_dsize = w_b[CW_W-1 -: CW_SIZE_W];
        sgn        = w_b[MANT_W];
        mant       = w_b[MANT_W-1:0];
        case (n_s1_dsize)
            8'd0:    madj = '0;
            8'd1:    madj = mant >> 16;
            8'd2:    madj = mant >> 8;
            default: madj = mant;
        endcase
        n_s1_neg = (w_op == OP_DECODE) && (|madj) && sgn;
        n_s1_ovf = (w_op == OP_DECODE) && (|madj) &&
                   ((n_s1_dsize > CW_OVF_ANY) ||
                    ((madj > MANT_BYTE_MAX) && (n_s1_dsize > CW_OVF_BYTE)) ||
                    ((madj > MANT_HALF_MAX) && (n_s1_dsize > CW_OVF_HALF)));

        n_s1_op     = w_op;
        n_s1_encneg = s_axis_tuser[OP_W];
        case (w_op)
            OP_ADD, OP_SUB: n_s1_data = sums;
            OP_AND:         n_s1_data = w_a & w_b;
            OP_OR:          n_s1_data = w_a | w_b;
            OP_XOR:         n_s1_data = w_a ^ w_b;
            OP_ENCODE:      n_s1_data = w_a;
            OP_DECODE:      n_s1_data = DATA_W'(madj);
            default:        n_s1_data = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_op     <= n_s1_op;
            r_s1_data   <= n_s1_data;
            r_s1_g      <= n_s1_g;
            r_s1_p      <= n_s1_p;
            r_s1_eq     <= n_s1_eq;
            r_s1_lt     <= n_s1_lt;
            r_s1_nz     <= n_s1_nz;
            r_s1_pos    <= n_s1_pos;
            r_s1_dsize  <= n_s1_dsize;
            r_s1_neg    <= n_s1_neg;
            r_s1_ovf    <= n_s1_ovf;
            r_s1_encneg <= n_s1_encneg;
        end
    end

    // ---------------- stage 2 ----------------
    logic               r_s2_valid;
    logic [OP_W-1:0]    r_s2_op;
    logic [DATA_W-1:0]  r_s2_data, n_s2_data;
    logic               r_s2_cmp, n_s2_cmp;
    logic [SIZE_W-1:0]  r_s2_size, n_s2_size;
    logic               r_s2_neg;
    logic               r_s2_ovf;
    logic               r_s2_encneg;

    // carry resolution, compare merge, bit length, decode placement
    always_comb begin
        logic                 c;
        logic                 lt_acc;
        logic                 eq_all;
        logic                 gt_all;
        logic [DATA_W-1:0]    addr;
        logic [BITS_W-1:0]    bits;
        logic [BITS_W:0]      bits_up;
        logic [CW_SIZE_W-1:0] dk;

        c    = 1'b0;
        addr = '0;
        for (int i = 0; i < WORD_COUNT; i++) begin
            addr[i*WIA_WORD_W +: WIA_WORD_W] = r_s1_data[i*WIA_WORD_W +: WIA_WORD_W]
                                              + WIA_WORD_W'(c);
            c = r_s1_g[i] | (r_s1_p[i] & c);
        end

        // higher lanes override lower ones
        lt_acc = 1'b0;
        for (int i = 0; i < WORD_COUNT; i++) begin
            lt_acc = r_s1_lt[i] | (r_s1_eq[i] & lt_acc);
        end
        eq_all = &r_s1_eq;
        gt_all = !lt_acc && !eq_all;
        case (r_s1_op)
            OP_EQ:   n_s2_cmp = eq_all;
            OP_NE:   n_s2_cmp = !eq_all;
            OP_LT:   n_s2_cmp = lt_acc;
            OP_GT:   n_s2_cmp = gt_all;
            OP_LE:   n_s2_cmp = !gt_all;
            OP_GE:   n_s2_cmp = !lt_acc;
            default: n_s2_cmp = 1'b0;
        endcase

        // bit length of the operand, rounded up to bytes
        bits = '0;
        for (int i = 0; i < WORD_COUNT; i++) begin
            if (r_s1_nz[i]) begin
                bits = BITS_W'(i * WIA_WORD_W) + BITS_W'(r_s1_pos[i]) + BITS_W'(1);
            end
        end
        bits_up   = {1'b0, bits} + (BITS_W+1)'(7);
        n_s2_size = bits_up[3 +: SIZE_W];

        dk = r_s1_dsize - CW_MANT_BYTES;
        case (r_s1_op)
            OP_ADD, OP_SUB: n_s2_data = addr;
            OP_DECODE: begin
                if (r_s1_dsize <= CW_MANT_BYTES) begin
                    n_s2_data = r_s1_data;
                end else if (dk < CW_SIZE_W'(DATA_W / 8)) begin
                    n_s2_data = DATA_W'(r_s1_data[MANT_W-1:0]) << {dk[BSH_W-1:0], 3'b000};
                end else begin
                    n_s2_data = '0;
                end
            end
            default: n_s2_data = r_s1_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_op     <= r_s1_op;
            r_s2_data   <= n_s2_data;
            r_s2_cmp    <= n_s2_cmp;
            r_s2_size   <= n_s2_size;
            r_s2_neg    <= r_s1_neg;
            r_s2_ovf    <= r_s1_ovf;
            r_s2_encneg <= r_s1_encneg;
        end
    end

    // ---------------- stage 3 (output register) ----------------
    logic [DATA_W-1:0]  r_s3_data, n_s3_data;
    logic               r_s3_cmp;
    logic               r_s3_neg;
    logic               r_s3_ovf;

    // compact encode: take the top three bytes, bump on sign-bit clash
    always_comb begin
        logic [MANT_B-1:0]    m;
        logic [1:0]           lsh;
        logic [BSH_W-1:0]     rsh;
        logic [DATA_W-1:0]    shifted;
        logic [CW_SIZE_W-1:0] sz;
        logic [CW_W-1:0]      cw;

        lsh     = 2'(SIZE_W'(3) - r_s2_size);
        rsh     = BSH_W'(r_s2_size - SIZE_W'(3));
        shifted = r_s2_data >> {rsh, 3'b000};
        if (r_s2_size <= SIZE_W'(3)) begin
            m = r_s2_data[MANT_B-1:0] << {lsh, 3'b000};
        end else begin
            m = shifted[MANT_B-1:0];
        end
        sz = CW_SIZE_W'(r_s2_size);
        if (m[MANT_W]) begin
            m  = m >> 8;
            sz = sz + CW_SIZE_W'(1);
        end
        cw = {sz, r_s2_encneg && (|m[MANT_W-1:0]), m[MANT_W-1:0]};

        if (r_s2_op == OP_ENCODE) begin
            n_s3_data = DATA_W'(cw);
        end else begin
            n_s3_data = r_s2_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_adv) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_data <= n_s3_data;
            r_s3_cmp  <= r_s2_cmp;
            r_s3_neg  <= r_s2_neg;
            r_s3_ovf  <= r_s2_ovf;
        end
    end

    assign m_axis_tvalid = r_s3_valid;
    assign m_axis_tdata  = r_s3_data;
    assign m_axis_tuser  = {r_s3_ovf, r_s3_neg, r_s3_cmp};

    // ---------------- assertions ----------------
    // a compare outcome never comes with result data
    a_cmp_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("compare result with nonzero data");

    // decode flags and compare outcome never share a word
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser[1] || m_axis_tuser[2])) |-> !m_axis_tuser[0])
        else $error("decode flag set together with compare outcome");

    // a word in stage 1 reaches stage 2 on an advance
    a_s1_to_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_adv) |=> r_s2_valid)
        else $error("word lost between stage 1 and stage 2");

    // a word in stage 2 stays put while the output stalls
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !w_adv) |=> (r_s2_valid && $stable(r_s2_data)))
        else $error("stage 2 word changed during stall");

endmodule

FILE: bench/tb_wide_integer_alu_with_compact_codec.sv
// Self-checking bench for the 256-bit ALU with compact codec: directed table plus random stream.
`timescale 1ns / 100ps

module tb_wide_integer_alu_with_compact_codec;
    import wialu_pkg::*;

    localparam int VAL_W      = WIA_WORD_COUNT * WIA_WORD_W;
    localparam int RAND_WORDS = 1200;
    localparam int CYCLE_CAP  = 400000;
    localparam int PIPE_DEPTH = 3;

    // codes the block leaves unused; they must answer all zero
    localparam logic [OP_W-1:0] OP_RSVD_D = 4'd13;
    localparam logic [OP_W-1:0] OP_RSVD_E = 4'd14;
    localparam logic [OP_W-1:0] OP_RSVD_F = 4'd15;

    typedef enum logic [1:0] {RX_OPEN, RX_PERIODIC, RX_RANDOM, RX_BURSTY} t_rx_mode;

    typedef struct {
        logic [VAL_W-1:0] result;
        logic             cmp;
        logic             neg;
        logic             ovf;
        int               idx;
        logic [OP_W-1:0]  op;
    } t_alu_answer;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
        logic             enc_neg;
        logic             known;
        t_alu_answer      answer;
    } t_alu_vector;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [2*VAL_W-1:0]    s_axis_tdata = '0;   // a_word0..a_word3, b_word0..b_word3
    logic [OP_W:0]         s_axis_tuser = '0;   // operation[3:0], encode_negative
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [VAL_W-1:0]      m_axis_tdata;        // result_word0..result_word3
    logic [2:0]            m_axis_tuser;        // compare_true, negative_flag, overflow_flag

    t_alu_answer pending_answers[$];
    t_alu_vector directed_rows[$];
    int          words_sent = 0;
    int          results_seen = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          op_count[16];

    t_rx_mode    rx_mode = RX_OPEN;
    int          rx_left = 0;
    int          rx_period = 2;
    int          rx_hold = 0;
    int          rx_tick = 0;

    wide_integer_alu_with_compact_codec #(
        .WORD_COUNT(WIA_WORD_COUNT)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // expected answer for one word
    function automatic t_alu_answer compute_answer(input logic [OP_W-1:0] op,
                                                   input logic [VAL_W-1:0] a,
                                                   input logic [VAL_W-1:0] b,
                                                   input logic enc_neg);
        t_alu_answer      ans;
        logic [CW_W-1:0]  cw;
        logic [7:0]       sz;
        logic [MANT_W-1:0] mant;
        logic [VAL_W-1:0] sh;
        int               nbits;
        int               i;
        ans = '{default: '0};
        case (op)
            OP_ADD: ans.result = a + b;
            OP_SUB: ans.result = a - b;
            OP_AND: ans.result = a & b;
            OP_OR:  ans.result = a | b;
            OP_XOR: ans.result = a ^ b;
            OP_EQ:  ans.cmp = (a == b);
            OP_NE:  ans.cmp = (a != b);
            OP_LT:  ans.cmp = (a < b);
            OP_GT:  ans.cmp = (a > b);
            OP_LE:  ans.cmp = (a <= b);
            OP_GE:  ans.cmp = (a >= b);
            OP_DECODE: begin
                cw   = b[CW_W-1:0];
                sz   = cw[CW_W-1:MANT_B];
                mant = cw[MANT_W-1:0];
                // small sizes drop mantissa bytes, larger ones move them up
                if (sz <= CW_MANT_BYTES) begin
                    mant       = mant >> (8 * (CW_MANT_BYTES - sz));
                    ans.result = VAL_W'(mant);
                end else begin
                    ans.result = VAL_W'(mant) << (8 * (sz - CW_MANT_BYTES));
                end
                ans.neg = (mant != '0) && cw[MANT_W];
                ans.ovf = (mant != '0) && ((sz > CW_OVF_ANY) ||
                          (mant > MANT_BYTE_MAX && sz > CW_OVF_BYTE) ||
                          (mant > MANT_HALF_MAX && sz > CW_OVF_HALF));
            end
            OP_ENCODE: begin
                nbits = 0;
                for (i = 0; i < VAL_W; i++)
                    if (a[i]) nbits = i + 1;
                sz = 8'((nbits + 7) / 8);
                if (sz <= CW_MANT_BYTES) begin
                    cw = a[CW_W-1:0] << (8 * (CW_MANT_BYTES - sz));
                end else begin
                    sh = a >> (8 * (sz - CW_MANT_BYTES));
                    cw = sh[CW_W-1:0];
                end
                // mantissa must not look negative: move down a byte
                if (cw[MANT_W]) begin
                    cw = cw >> 8;
                    sz = sz + 8'd1;
                end
                cw = cw | {sz, 24'h0};
                if (enc_neg && cw[MANT_W-1:0] != '0)
                    cw[MANT_W] = 1'b1;
                ans.result = VAL_W'(cw);
            end
            default: ;
        endcase
        return ans;
    endfunction

    function automatic t_alu_vector make_row(input logic [OP_W-1:0] op,
                                             input logic [VAL_W-1:0] a,
                                             input logic [VAL_W-1:0] b,
                                             input logic enc_neg,
                                             input logic known,
                                             input logic [VAL_W-1:0] result,
                                             input logic [2:0] flags);
        t_alu_vector v;
        v.op             = op;
        v.a              = a;
        v.b              = b;
        v.enc_neg        = enc_neg;
        v.known          = known;
        v.answer         = '{default: '0};
        v.answer.result  = result;
        v.answer.cmp     = flags[0];
        v.answer.neg     = flags[1];
        v.answer.ovf     = flags[2];
        return v;
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        logic [VAL_W-1:0] v;
        int               i;
        for (i = 0; i < VAL_W / 32; i++)
            v[i*32 +: 32] = $urandom;
        return v;
    endfunction

    // operand with a bias towards corners and short bit lengths
    function automatic logic [VAL_W-1:0] shaped_value();
        logic [VAL_W-1:0] one;
        one = VAL_W'(1);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return rand_value() >> $urandom_range(0, VAL_W);
            3:       return one << $urandom_range(0, VAL_W - 1);
            4:       return ~(one << $urandom_range(0, VAL_W - 1));
            default: return rand_value();
        endcase
    endfunction

    function automatic t_alu_vector random_vector();
        t_alu_vector       v;
        logic [VAL_W-1:0]  one;
        logic [MANT_W-1:0] mant;
        logic [7:0]        sz;
        one = VAL_W'(1);
        if ($urandom_range(0, 19) == 0)
            v.op = OP_W'($urandom_range(OP_RSVD_D, OP_RSVD_F));
        else
            v.op = OP_W'($urandom_range(OP_ADD, OP_ENCODE));
        v.a       = shaped_value();
        v.b       = shaped_value();
        v.enc_neg = 1'($urandom_range(0, 1));
        v.known   = 1'b0;
        v.answer  = '{default: '0};
        case (v.op)
            // long carry and borrow chains
            OP_ADD: if ($urandom_range(0, 2) == 0) v.b = ~v.a + VAL_W'($urandom_range(0, 2));
            OP_SUB: if ($urandom_range(0, 2) == 0) v.b = v.a - VAL_W'($urandom_range(0, 2)) + one;
            // equal operands, operands one bit apart, or unrelated operands
            OP_EQ, OP_NE, OP_LT, OP_GT, OP_LE, OP_GE: begin
                case ($urandom_range(0, 3))
                    0:       v.b = v.a;
                    1:       v.b = v.a ^ (one << $urandom_range(0, VAL_W - 1));
                    default: ;
                endcase
            end
            OP_DECODE: begin
                case ($urandom_range(0, 4))
                    0:       sz = 8'($urandom_range(0, 3));
                    1:       sz = 8'($urandom_range(4, 31));
                    2:       sz = 8'($urandom_range(32, 35));
                    3:       sz = 8'($urandom_range(36, 255));
                    default: sz = 8'($urandom_range(30, 34));
                endcase
                case ($urandom_range(0, 3))
                    0:       mant = '0;
                    1:       mant = MANT_W'($urandom_range(1, 255));
                    2:       mant = MANT_W'($urandom_range(256, 65535));
                    default: mant = MANT_W'($urandom);
                endcase
                v.b[CW_W-1:0] = {sz, 1'($urandom_range(0, 1)), mant};
            end
            OP_ENCODE: v.a = rand_value() >> $urandom_range(0, VAL_W);
            default: ;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("[%0t] %s", $time, what);
    endtask

    // present one word and hold it until taken
    task automatic send_word(input t_alu_vector v);
        t_alu_answer ans;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {v.b, v.a};
        s_axis_tuser  <= {v.enc_neg, v.op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (v.known)
            ans = v.answer;
        else
            ans = compute_answer(v.op, v.a, v.b, v.enc_neg);
        ans.idx = words_sent;
        ans.op  = v.op;
        pending_answers.push_back(ans);
        words_sent++;
        op_count[v.op]++;
    endtask

    task automatic idle_for(input int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    // receiver back-pressure: a random mode, redrawn whenever its run ends
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_left == 0) begin
            rx_mode   <= t_rx_mode'($urandom_range(0, 3));
            rx_left   <= $urandom_range(32, 200);
            rx_period <= $urandom_range(2, 7);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:     m_axis_tready <= 1'b1;
            RX_PERIODIC: m_axis_tready <= (rx_tick % rx_period) != 0;
            RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 99) >= 35);
            default: begin
                if (rx_hold != 0) begin
                    m_axis_tready <= 1'b0;
                    rx_hold       <= rx_hold - 1;
                end else if ($urandom_range(0, 15) == 0) begin
                    m_axis_tready <= 1'b0;
                    rx_hold       <= $urandom_range(3, 20);
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        endcase
    end

    // compare every word taken from m_axis with the oldest pending answer
    always @(posedge i_clk) begin : check_results
        t_alu_answer      want;
        logic [WIA_WORD_W-1:0] got_w;
        logic [WIA_WORD_W-1:0] want_w;
        int               w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_answers.size() == 0) begin
                report_mismatch($sformatf("result %h/%b with nothing pending",
                                          m_axis_tdata, m_axis_tuser));
            end else begin
                want = pending_answers.pop_front();
                for (w = 0; w < WIA_WORD_COUNT; w++) begin
                    got_w  = m_axis_tdata[w*WIA_WORD_W +: WIA_WORD_W];
                    want_w = want.result[w*WIA_WORD_W +: WIA_WORD_W];
                    if (got_w !== want_w)
                        report_mismatch($sformatf("word %0d op %0d: result_word%0d %h, want %h",
                                                  want.idx, want.op, w, got_w, want_w));
                end
                if (m_axis_tuser[0] !== want.cmp)
                    report_mismatch($sformatf("word %0d op %0d: compare_true %b, want %b",
                                              want.idx, want.op, m_axis_tuser[0], want.cmp));
                if (m_axis_tuser[1] !== want.neg)
                    report_mismatch($sformatf("word %0d op %0d: negative_flag %b, want %b",
                                              want.idx, want.op, m_axis_tuser[1], want.neg));
                if (m_axis_tuser[2] !== want.ovf)
                    report_mismatch($sformatf("word %0d op %0d: overflow_flag %b, want %b",
                                              want.idx, want.op, m_axis_tuser[2], want.ovf));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("wide_integer_alu_with_compact_codec: mismatch");
            $finish;
        end
    end

    // stimulus
    initial begin : stimulus
        int sent;
        int burst;
        int k;
        int ops_hit;
        logic [VAL_W-1:0] ones;
        ones = '1;
        foreach (op_count[oi]) op_count[oi] = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners; typed answers where they are obvious
        directed_rows.push_back(make_row(OP_ADD, ones, VAL_W'(1), 1'b0, 1'b1, '0, 3'b000));
        directed_rows.push_back(make_row(OP_SUB, '0, VAL_W'(1), 1'b0, 1'b1, ones, 3'b000));
        directed_rows.push_back(make_row(OP_SUB, VAL_W'(1) << 128, VAL_W'(1), 1'b0, 1'b0,
                                         '0, 3'b000));
        directed_rows.push_back(make_row(OP_AND, ones, ones, 1'b0, 1'b1, ones, 3'b000));
        directed_rows.push_back(make_row(OP_OR, '0, ones, 1'b0, 1'b1, ones, 3'b000));
        directed_rows.push_back(make_row(OP_XOR, ones, ones, 1'b1, 1'b1, '0, 3'b000));
        directed_rows.push_back(make_row(OP_EQ, ones, ones, 1'b0, 1'b1, '0, 3'b001));
        directed_rows.push_back(make_row(OP_NE, ones, ones, 1'b0, 1'b1, '0, 3'b000));
        directed_rows.push_back(make_row(OP_LT, '0, ones, 1'b0, 1'b1, '0, 3'b001));
        directed_rows.push_back(make_row(OP_GT, '0, ones, 1'b0, 1'b1, '0, 3'b000));
        directed_rows.push_back(make_row(OP_LE, ones, ones, 1'b0, 1'b1, '0, 3'b001));
        directed_rows.push_back(make_row(OP_GE, '0, ones, 1'b0, 1'b1, '0, 3'b000));
        // decode: exact size, truncating size, sign, sign on zero mantissa, huge size
        directed_rows.push_back(make_row(OP_DECODE, '0, VAL_W'(32'h03123456), 1'b0, 1'b1,
                                         VAL_W'(32'h00123456), 3'b000));
        directed_rows.push_back(make_row(OP_DECODE, '0, VAL_W'(32'h01123456), 1'b0, 1'b1,
                                         VAL_W'(32'h00000012), 3'b000));
        directed_rows.push_back(make_row(OP_DECODE, '0, VAL_W'(32'h04923456), 1'b0, 1'b1,
                                         VAL_W'(32'h12345600), 3'b010));
        directed_rows.push_back(make_row(OP_DECODE, '0, VAL_W'(32'h04800000), 1'b0, 1'b1,
                                         '0, 3'b000));
        directed_rows.push_back(make_row(OP_DECODE, '0, VAL_W'(32'hff123456), 1'b0, 1'b1,
                                         '0, 3'b100));
        // decode at the overflow limits, ignored bits of B all set
        directed_rows.push_back(make_row(OP_DECODE, '0, VAL_W'(32'h22000001), 1'b0, 1'b0,
                                         '0, 3'b000));
        directed_rows.push_back(make_row(OP_DECODE, '0, VAL_W'(32'h21010000), 1'b0, 1'b0,
                                         '0, 3'b000));
        directed_rows.push_back(make_row(OP_DECODE, '0,
                                         {{(VAL_W-32){1'b1}}, 32'h20ffffff}, 1'b1, 1'b0,
                                         '0, 3'b000));
        // encode: zero, full width with sign, sign-bit bump, plain three bytes
        directed_rows.push_back(make_row(OP_ENCODE, '0, '0, 1'b1, 1'b1, '0, 3'b000));
        directed_rows.push_back(make_row(OP_ENCODE, ones, ones, 1'b1, 1'b0, '0, 3'b000));
        directed_rows.push_back(make_row(OP_ENCODE, VAL_W'(32'h80), '0, 1'b0, 1'b0,
                                         '0, 3'b000));
        directed_rows.push_back(make_row(OP_ENCODE, VAL_W'(32'h123456), '0, 1'b1, 1'b0,
                                         '0, 3'b000));
        // unused code answers zero whatever the operands
        directed_rows.push_back(make_row(OP_RSVD_F, ones, ones, 1'b1, 1'b1, '0, 3'b000));

        foreach (directed_rows[ri]) begin
            send_word(directed_rows[ri]);
            if ($urandom_range(0, 3) == 0)
                idle_for($urandom_range(1, 3));
        end
        drain_results();

        // random stream in bursts; one full drain half way
        sent = 0;
        while (sent < RAND_WORDS) begin
            burst = $urandom_range(1, 48);
            for (k = 0; k < burst && sent < RAND_WORDS; k++) begin
                send_word(random_vector());
                sent++;
                if (sent == RAND_WORDS / 2)
                    drain_results();
            end
            if ($urandom_range(0, 3) != 0)
                idle_for($urandom_range(1, 8));
        end

        drain_results();
        repeat (PIPE_DEPTH * 4) @(posedge i_clk);

        ops_hit = 0;
        foreach (op_count[oi])
            if (op_count[oi] != 0) ops_hit++;
        $display("run: %0d words sent (%0d table rows, %0d random), %0d of 16 op codes used",
                 words_sent, directed_rows.size(), RAND_WORDS, ops_hit);
        $display("run: %0d results checked under varied stalls, %0d mismatches",
                 results_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("wide_integer_alu_with_compact_codec: match");
        end else begin
            $display("wide_integer_alu_with_compact_codec: mismatch");
        end
        $finish;
    end

endmodule
